/* hdl/c_subset_tokenizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// c_subset_tokenizer_unit_assert.svh
// Assertion macros shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_TOKENIZER_UNIT_ASSERT_SVH
`define C_SUBSET_TOKENIZER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTOK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ctok: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ctok: next-cycle check failed");

`endif

/* hdl/ctok_pkg.sv */
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, codes and character helpers of the C subset tokenizer.
// ----------------------------------------------------------------------------
package ctok_pkg;

	localparam int MAX_IDENT_LEN_DEF = 63;
	localparam int POS_BITS_DEF      = 16;

	localparam int CH_W    = 8;
	localparam int KIND_W  = 5;
	localparam int VALUE_W = 31;
	localparam int LEN_W   = 6;
	localparam int MODE_W  = 4;
	localparam int KW_W    = 4;

	// digit counts saturate at the largest length the port can show
	localparam int NUM_LEN_CAP = (1 << LEN_W) - 1;

	// one input byte causes at most this many tokens
	localparam int MAX_BURST   = 3;
	// output queue depth, power of two
	localparam int QUEUE_DEPTH = 8;

	localparam logic [VALUE_W-1:0] INT_MAX = {VALUE_W{1'b1}};

	localparam logic [LEN_W-1:0] LEN_ZERO   = 6'd0;
	localparam logic [LEN_W-1:0] LEN_ONE    = 6'd1;
	localparam logic [LEN_W-1:0] LEN_TWO    = 6'd2;
	localparam logic [LEN_W-1:0] LEN_KW_INT = 6'd3;
	localparam logic [LEN_W-1:0] LEN_KW_RET = 6'd6;

	// characters
	localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
	localparam logic [CH_W-1:0] CH_AMP    = 8'h26;
	localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
	localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
	localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
	localparam logic [CH_W-1:0] CH_UA     = 8'h41;
	localparam logic [CH_W-1:0] CH_UZ     = 8'h5A;
	localparam logic [CH_W-1:0] CH_LA     = 8'h61;
	localparam logic [CH_W-1:0] CH_E      = 8'h65;
	localparam logic [CH_W-1:0] CH_I      = 8'h69;
	localparam logic [CH_W-1:0] CH_N      = 8'h6E;
	localparam logic [CH_W-1:0] CH_R      = 8'h72;
	localparam logic [CH_W-1:0] CH_T      = 8'h74;
	localparam logic [CH_W-1:0] CH_U      = 8'h75;
	localparam logic [CH_W-1:0] CH_LZ     = 8'h7A;
	localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CH_W-1:0] CH_PIPE   = 8'h7C;
	localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CH_W-1:0] CH_TILDE  = 8'h7E;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_EOF       = 5'd0;
	localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd1;
	localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd2;
	localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd3;
	localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd4;
	localparam logic [KIND_W-1:0] KIND_SEMI      = 5'd5;
	localparam logic [KIND_W-1:0] KIND_MINUS     = 5'd6;
	localparam logic [KIND_W-1:0] KIND_TILDE     = 5'd7;
	localparam logic [KIND_W-1:0] KIND_NOT       = 5'd8;
	localparam logic [KIND_W-1:0] KIND_NE        = 5'd9;
	localparam logic [KIND_W-1:0] KIND_PLUS      = 5'd10;
	localparam logic [KIND_W-1:0] KIND_STAR      = 5'd11;
	localparam logic [KIND_W-1:0] KIND_SLASH     = 5'd12;
	localparam logic [KIND_W-1:0] KIND_LAND      = 5'd13;
	localparam logic [KIND_W-1:0] KIND_AMP       = 5'd14;
	localparam logic [KIND_W-1:0] KIND_LOR       = 5'd15;
	localparam logic [KIND_W-1:0] KIND_PIPE      = 5'd16;
	localparam logic [KIND_W-1:0] KIND_EQEQ      = 5'd17;
	localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd18;
	localparam logic [KIND_W-1:0] KIND_LE        = 5'd19;
	localparam logic [KIND_W-1:0] KIND_LT        = 5'd20;
	localparam logic [KIND_W-1:0] KIND_GE        = 5'd21;
	localparam logic [KIND_W-1:0] KIND_GT        = 5'd22;
	localparam logic [KIND_W-1:0] KIND_INT_LIT   = 5'd23;
	localparam logic [KIND_W-1:0] KIND_KW_INT    = 5'd24;
	localparam logic [KIND_W-1:0] KIND_KW_RETURN = 5'd25;
	localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd26;

	// pending token modes
	localparam logic [MODE_W-1:0] MODE_IDLE   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_NUM    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_ID     = 4'd2;
	localparam logic [MODE_W-1:0] MODE_OP_NOT = 4'd3;
	localparam logic [MODE_W-1:0] MODE_OP_AND = 4'd4;
	localparam logic [MODE_W-1:0] MODE_OP_OR  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_OP_EQ  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_OP_LT  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_OP_GT  = 4'd8;

	// keyword prefix tracker
	localparam logic [KW_W-1:0] KW_NONE   = 4'd0;
	localparam logic [KW_W-1:0] KW_I      = 4'd1;
	localparam logic [KW_W-1:0] KW_IN     = 4'd2;
	localparam logic [KW_W-1:0] KW_INT    = 4'd3;
	localparam logic [KW_W-1:0] KW_R      = 4'd4;
	localparam logic [KW_W-1:0] KW_RE     = 4'd5;
	localparam logic [KW_W-1:0] KW_RET    = 4'd6;
	localparam logic [KW_W-1:0] KW_RETU   = 4'd7;
	localparam logic [KW_W-1:0] KW_RETUR  = 4'd8;
	localparam logic [KW_W-1:0] KW_RETURN = 4'd9;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [LEN_W-1:0]   length;
		logic               ovf;
	} tok_t;

	function automatic logic is_alpha(input logic [CH_W-1:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic is_digit(input logic [CH_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// space plus tab through carriage return
	function automatic logic is_ws(input logic [CH_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// kind of a single-character punctuator; KIND_EOF when c is none
	function automatic logic [KIND_W-1:0] single_kind(input logic [CH_W-1:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_SEMI:   k = KIND_SEMI;
			CH_MINUS:  k = KIND_MINUS;
			CH_TILDE:  k = KIND_TILDE;
			CH_PLUS:   k = KIND_PLUS;
			CH_STAR:   k = KIND_STAR;
			CH_SLASH:  k = KIND_SLASH;
			default:   k = KIND_EOF;
		endcase
		return k;
	endfunction

	// pending mode of an operator that may take a second byte; MODE_IDLE when none
	function automatic logic [MODE_W-1:0] op_mode(input logic [CH_W-1:0] c);
		logic [MODE_W-1:0] m;
		unique case (c)
			CH_BANG: m = MODE_OP_NOT;
			CH_AMP:  m = MODE_OP_AND;
			CH_PIPE: m = MODE_OP_OR;
			CH_EQ:   m = MODE_OP_EQ;
			CH_LT:   m = MODE_OP_LT;
			CH_GT:   m = MODE_OP_GT;
			default: m = MODE_IDLE;
		endcase
		return m;
	endfunction

	function automatic logic [CH_W-1:0] op_second(input logic [MODE_W-1:0] m);
		logic [CH_W-1:0] c;
		unique case (m) inside
			MODE_OP_AND: c = CH_AMP;
			MODE_OP_OR:  c = CH_PIPE;
			default:     c = CH_EQ;
		endcase
		return c;
	endfunction

	function automatic logic [KIND_W-1:0] op_two_kind(input logic [MODE_W-1:0] m);
		logic [KIND_W-1:0] k;
		unique case (m)
			MODE_OP_NOT: k = KIND_NE;
			MODE_OP_AND: k = KIND_LAND;
			MODE_OP_OR:  k = KIND_LOR;
			MODE_OP_EQ:  k = KIND_EQEQ;
			MODE_OP_LT:  k = KIND_LE;
			default:     k = KIND_GE;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] op_one_kind(input logic [MODE_W-1:0] m);
		logic [KIND_W-1:0] k;
		unique case (m)
			MODE_OP_NOT: k = KIND_NOT;
			MODE_OP_AND: k = KIND_AMP;
			MODE_OP_OR:  k = KIND_PIPE;
			MODE_OP_EQ:  k = KIND_ASSIGN;
			MODE_OP_LT:  k = KIND_LT;
			default:     k = KIND_GT;
		endcase
		return k;
	endfunction

	// advance the keyword prefix tracker by one alphabetic byte
	function automatic logic [KW_W-1:0] kw_next(input logic [KW_W-1:0] m,
			input logic [CH_W-1:0] c);
		logic [KW_W-1:0] n;
		unique case (m)
			KW_I:     n = (c == CH_N) ? KW_IN     : KW_NONE;
			KW_IN:    n = (c == CH_T) ? KW_INT    : KW_NONE;
			KW_R:     n = (c == CH_E) ? KW_RE     : KW_NONE;
			KW_RE:    n = (c == CH_T) ? KW_RET    : KW_NONE;
			KW_RET:   n = (c == CH_U) ? KW_RETU   : KW_NONE;
			KW_RETU:  n = (c == CH_R) ? KW_RETUR  : KW_NONE;
			KW_RETUR: n = (c == CH_N) ? KW_RETURN : KW_NONE;
			default:  n = KW_NONE;
		endcase
		return n;
	endfunction

	// kind of a finished word, given the byte that ends it
	function automatic logic [KIND_W-1:0] ident_kind(input logic [KW_W-1:0] kw,
			input logic at_end, input logic [CH_W-1:0] c);
		logic [KIND_W-1:0] k;
		if (kw == KW_INT && (at_end || is_ws(c))) begin
			k = KIND_KW_INT;
		end else if (kw == KW_RETURN && (at_end || is_ws(c) || c == CH_SEMI)) begin
			k = KIND_KW_RETURN;
		end else begin
			k = KIND_IDENT;
		end
		return k;
	endfunction

endpackage

/* hdl/c_subset_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// c_subset_tokenizer_unit
// Streaming tokenizer for a small C subset: source bytes in, tokens out.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | ch, end_of_text
//  out     | out_valid/out_stall| token_kind, int_value, start_pos, token_length,
//          |                    | overflow, last_of_run
//
//  One byte is taken per cycle while the output queue has room for a full
//  burst of three tokens; a token leaves the queue one per cycle while the
//  out side does not stall. A byte is registered at acceptance, scanned once
//  the queue has room, and its tokens then enter the queue for the out side.
//  Bytes that produce more than one token slow intake only once more than five
//  tokens wait in the queue.
//  Reset clears the scanner state and empties the queue; no clearing pass.
//  A stalled out side holds the head token; the in side stalls only while a
//  registered byte waits for the queue to have room for a full burst.
// ----------------------------------------------------------------------------

module c_subset_tokenizer_unit #(
	parameter int MAX_IDENT_LEN = ctok_pkg::MAX_IDENT_LEN_DEF,
	parameter int POS_BITS      = ctok_pkg::POS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ctok_pkg::CH_W-1:0]      ch,
	input  logic                           end_of_text,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ctok_pkg::KIND_W-1:0]    token_kind,
	output logic [ctok_pkg::VALUE_W-1:0]   int_value,
	output logic [POS_BITS-1:0]            start_pos,
	output logic [ctok_pkg::LEN_W-1:0]     token_length,
	output logic                           overflow,
	output logic                           last_of_run
);

	// input register
	logic                        vld_s1;
	logic [ctok_pkg::CH_W-1:0]   ch_s1;
	logic                        eot_s1;

	logic                        room;
	logic                        fire;
	logic                        in_take;

	logic [ctok_pkg::MAX_BURST-1:0]               cand_vld;
	ctok_pkg::tok_t [ctok_pkg::MAX_BURST-1:0]     cand_tok;
	logic [ctok_pkg::MAX_BURST-1:0][POS_BITS-1:0] cand_start;

	ctok_pkg::tok_t              head_tok;

	// scan the registered byte once the queue can absorb a full burst
	assign fire     = vld_s1 && room;
	// hold the input register while its byte waits for queue room
	assign in_stall = vld_s1 && !room;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// payload of the input register: load on every accepted transaction
	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1  <= ch;
			eot_s1 <= end_of_text;
		end
	end

	ctok_core #(
		.MAX_IDENT_LEN (MAX_IDENT_LEN),
		.POS_BITS      (POS_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.ch_s1      (ch_s1),
		.eot_s1     (eot_s1),
		.cand_vld   (cand_vld),
		.cand_tok   (cand_tok),
		.cand_start (cand_start)
	);

	ctok_queue #(
		.POS_BITS (POS_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (fire),
		.cand_vld   (cand_vld),
		.cand_tok   (cand_tok),
		.cand_start (cand_start),
		.room       (room),
		.head_vld   (out_valid),
		.pop        (!out_stall),
		.head_tok   (head_tok),
		.head_start (start_pos),
		.head_last  (last_of_run)
	);

	// split the head entry onto the output ports
	assign token_kind   = head_tok.kind;
	assign int_value    = head_tok.value;
	assign token_length = head_tok.length;
	assign overflow     = head_tok.ovf;

endmodule

/* hdl/ctok_core.sv */
// ----------------------------------------------------------------------------
// ctok_core
// Scanner state and the single-pass logic that turns one byte into tokens.
// ----------------------------------------------------------------------------
`include "c_subset_tokenizer_unit_assert.svh"

module ctok_core #(
	parameter int MAX_IDENT_LEN = ctok_pkg::MAX_IDENT_LEN_DEF,
	parameter int POS_BITS      = ctok_pkg::POS_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        fire,
	input  logic [ctok_pkg::CH_W-1:0]                   ch_s1,
	input  logic                                        eot_s1,
	output logic [ctok_pkg::MAX_BURST-1:0]              cand_vld,
	output ctok_pkg::tok_t [ctok_pkg::MAX_BURST-1:0]    cand_tok,
	output logic [ctok_pkg::MAX_BURST-1:0][POS_BITS-1:0] cand_start
);

	localparam int LCW = $clog2(MAX_IDENT_LEN + 1);
	localparam int LW  = (LCW > ctok_pkg::LEN_W) ? LCW : ctok_pkg::LEN_W;
	localparam int ACC_W = ctok_pkg::VALUE_W + 4;

	logic [ctok_pkg::MODE_W-1:0]  mode_q;
	logic [ctok_pkg::VALUE_W-1:0] accum_q;
	logic [LW-1:0]                len_q;
	logic [ctok_pkg::KW_W-1:0]    kw_q;
	logic [POS_BITS-1:0]          start_q;
	logic [POS_BITS-1:0]          bp_q;
	logic                         ovf_q;

	logic [ctok_pkg::MODE_W-1:0]  m_mode;
	logic [ctok_pkg::VALUE_W-1:0] m_accum;
	logic [LW-1:0]                m_len;
	logic [ctok_pkg::KW_W-1:0]    m_kw;
	logic [POS_BITS-1:0]          m_start;
	logic                         m_ovf;

	logic                         at_end0;
	logic                         end_any;
	logic                         consumed;
	logic [POS_BITS-1:0]          pos_nx;
	logic [ACC_W-1:0]             acc_ext;
	logic                         acc_sat;
	logic [ctok_pkg::KIND_W-1:0]  sk;
	logic [ctok_pkg::MODE_W-1:0]  om;

	logic                         a_vld;
	ctok_pkg::tok_t               a_tok;
	logic                         b_vld;
	ctok_pkg::tok_t               b_tok;
	logic                         c_vld;
	ctok_pkg::tok_t               c_tok;

	function automatic ctok_pkg::tok_t ident_tok(input logic [ctok_pkg::KW_W-1:0] kw,
			input logic [LW-1:0] len, input logic ovf, input logic at_end,
			input logic [ctok_pkg::CH_W-1:0] c);
		ctok_pkg::tok_t t;
		t.kind  = ctok_pkg::ident_kind(kw, at_end, c);
		t.value = '0;
		if (t.kind == ctok_pkg::KIND_KW_INT) begin
			t.length = ctok_pkg::LEN_KW_INT;
			t.ovf    = 1'b0;
		end else if (t.kind == ctok_pkg::KIND_KW_RETURN) begin
			t.length = ctok_pkg::LEN_KW_RET;
			t.ovf    = 1'b0;
		end else begin
			t.length = len[ctok_pkg::LEN_W-1:0];
			t.ovf    = ovf;
		end
		return t;
	endfunction

	function automatic ctok_pkg::tok_t num_tok(input logic [ctok_pkg::VALUE_W-1:0] v,
			input logic [LW-1:0] len, input logic ovf);
		ctok_pkg::tok_t t;
		t.kind   = ctok_pkg::KIND_INT_LIT;
		t.value  = v;
		t.length = len[ctok_pkg::LEN_W-1:0];
		t.ovf    = ovf;
		return t;
	endfunction

	function automatic ctok_pkg::tok_t op_tok(input logic [ctok_pkg::KIND_W-1:0] k,
			input logic [ctok_pkg::LEN_W-1:0] len);
		ctok_pkg::tok_t t;
		t.kind   = k;
		t.value  = '0;
		t.length = len;
		t.ovf    = 1'b0;
		return t;
	endfunction

	always_comb begin
		at_end0 = (ch_s1 == ctok_pkg::CH_NUL);
		end_any = at_end0 || eot_s1;
		pos_nx  = bp_q + 1'b1;
		acc_ext = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
			+ {{(ACC_W - 4){1'b0}}, ch_s1[3:0]};
		acc_sat = acc_ext > {4'b0, ctok_pkg::INT_MAX};
		sk      = ctok_pkg::single_kind(ch_s1);
		om      = ctok_pkg::op_mode(ch_s1);

		m_mode   = mode_q;
		m_accum  = accum_q;
		m_len    = len_q;
		m_kw     = kw_q;
		m_start  = start_q;
		m_ovf    = ovf_q;
		consumed = 1'b0;
		a_vld    = 1'b0;
		a_tok    = '0;
		b_vld    = 1'b0;
		b_tok    = '0;
		c_vld    = 1'b0;
		c_tok    = '0;

		// settle the pending token against this byte
		unique case (mode_q) inside
			ctok_pkg::MODE_NUM: begin
				if (!at_end0 && ctok_pkg::is_digit(ch_s1)) begin
					consumed = 1'b1;
					if (acc_sat) begin
						m_accum = ctok_pkg::INT_MAX;
						m_ovf   = 1'b1;
					end else begin
						m_accum = acc_ext[ctok_pkg::VALUE_W-1:0];
					end
					if (len_q < LW'(ctok_pkg::NUM_LEN_CAP)) begin
						m_len = len_q + 1'b1;
					end
				end else begin
					a_vld  = 1'b1;
					a_tok  = num_tok(accum_q, len_q, ovf_q);
					m_mode = ctok_pkg::MODE_IDLE;
				end
			end
			ctok_pkg::MODE_ID: begin
				if (!at_end0 && ctok_pkg::is_alpha(ch_s1)) begin
					consumed = 1'b1;
					m_kw     = ctok_pkg::kw_next(kw_q, ch_s1);
					if (len_q < LW'(MAX_IDENT_LEN)) begin
						m_len = len_q + 1'b1;
					end else begin
						m_ovf = 1'b1;
					end
				end else begin
					a_vld  = 1'b1;
					a_tok  = ident_tok(kw_q, len_q, ovf_q, at_end0, ch_s1);
					m_mode = ctok_pkg::MODE_IDLE;
				end
			end
			ctok_pkg::MODE_OP_NOT, ctok_pkg::MODE_OP_AND, ctok_pkg::MODE_OP_OR,
			ctok_pkg::MODE_OP_EQ, ctok_pkg::MODE_OP_LT, ctok_pkg::MODE_OP_GT: begin
				a_vld  = 1'b1;
				m_mode = ctok_pkg::MODE_IDLE;
				if (!at_end0 && ch_s1 == ctok_pkg::op_second(mode_q)) begin
					consumed = 1'b1;
					a_tok    = op_tok(ctok_pkg::op_two_kind(mode_q), ctok_pkg::LEN_TWO);
				end else begin
					a_tok = op_tok(ctok_pkg::op_one_kind(mode_q), ctok_pkg::LEN_ONE);
				end
			end
			default: begin
				m_mode = ctok_pkg::MODE_IDLE;
			end
		endcase

		// start a new token, skip space and newline
		if (!consumed && !at_end0 && ch_s1 != ctok_pkg::CH_SPACE
				&& ch_s1 != ctok_pkg::CH_NL) begin
			m_start = bp_q;
			m_accum = '0;
			m_len   = LW'(1);
			m_ovf   = 1'b0;
			m_kw    = ctok_pkg::KW_NONE;
			if (sk != ctok_pkg::KIND_EOF) begin
				b_vld = 1'b1;
				b_tok = op_tok(sk, ctok_pkg::LEN_ONE);
			end else if (om != ctok_pkg::MODE_IDLE) begin
				m_mode = om;
			end else if (ctok_pkg::is_digit(ch_s1)) begin
				m_mode  = ctok_pkg::MODE_NUM;
				m_accum = {{(ctok_pkg::VALUE_W - 4){1'b0}}, ch_s1[3:0]};
			end else begin
				m_mode = ctok_pkg::MODE_ID;
				if (ch_s1 == ctok_pkg::CH_I) begin
					m_kw = ctok_pkg::KW_I;
				end else if (ch_s1 == ctok_pkg::CH_R) begin
					m_kw = ctok_pkg::KW_R;
				end
			end
		end

		// end mark on a real byte: flush what is left pending
		if (eot_s1 && !at_end0) begin
			unique case (m_mode) inside
				ctok_pkg::MODE_NUM: begin
					c_vld = 1'b1;
					c_tok = num_tok(m_accum, m_len, m_ovf);
				end
				ctok_pkg::MODE_ID: begin
					c_vld = 1'b1;
					c_tok = ident_tok(m_kw, m_len, m_ovf, 1'b1, ch_s1);
				end
				ctok_pkg::MODE_OP_NOT, ctok_pkg::MODE_OP_AND, ctok_pkg::MODE_OP_OR,
				ctok_pkg::MODE_OP_EQ, ctok_pkg::MODE_OP_LT, ctok_pkg::MODE_OP_GT: begin
					c_vld = 1'b1;
					c_tok = op_tok(ctok_pkg::op_one_kind(m_mode), ctok_pkg::LEN_ONE);
				end
				default: begin
					c_vld = 1'b0;
				end
			endcase
		end

		// slot 0: settled token, slot 1: new single or flushed token, slot 2: eof
		cand_vld[0]   = a_vld;
		cand_tok[0]   = a_tok;
		cand_start[0] = start_q;
		cand_vld[1]   = b_vld || c_vld;
		cand_tok[1]   = b_vld ? b_tok : c_tok;
		cand_start[1] = m_start;
		cand_vld[2]   = end_any;
		cand_tok[2]   = op_tok(ctok_pkg::KIND_EOF, ctok_pkg::LEN_ZERO);
		cand_start[2] = at_end0 ? bp_q : pos_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ctok_pkg::MODE_IDLE;
			accum_q <= '0;
			len_q   <= '0;
			kw_q    <= ctok_pkg::KW_NONE;
			start_q <= '0;
			bp_q    <= '0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			if (end_any) begin
				mode_q  <= ctok_pkg::MODE_IDLE;
				accum_q <= '0;
				len_q   <= '0;
				kw_q    <= ctok_pkg::KW_NONE;
				start_q <= '0;
				bp_q    <= '0;
				ovf_q   <= 1'b0;
			end else begin
				mode_q  <= m_mode;
				accum_q <= m_accum;
				len_q   <= m_len;
				kw_q    <= m_kw;
				start_q <= m_start;
				bp_q    <= pos_nx;
				ovf_q   <= m_ovf;
			end
		end
	end

	`CTOK_ASSERT_NEXT(a_end_clears, clk, arst_n, fire && end_any, mode_q == ctok_pkg::MODE_IDLE && bp_q == '0)
	`CTOK_ASSERT_SAME(a_op_resolves, clk, arst_n, mode_q >= ctok_pkg::MODE_OP_NOT && mode_q <= ctok_pkg::MODE_OP_GT, cand_vld[0])
	`CTOK_ASSERT_SAME(a_slot1_excl, clk, arst_n, b_vld, !c_vld)

endmodule

/* hdl/ctok_queue.sv */
// ----------------------------------------------------------------------------
// ctok_queue
// Output queue: takes up to three tokens a cycle, hands out one a cycle while popped.
// ----------------------------------------------------------------------------
`include "c_subset_tokenizer_unit_assert.svh"

module ctok_queue #(
	parameter int POS_BITS = ctok_pkg::POS_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         wr_en,
	input  logic [ctok_pkg::MAX_BURST-1:0]               cand_vld,
	input  ctok_pkg::tok_t [ctok_pkg::MAX_BURST-1:0]     cand_tok,
	input  logic [ctok_pkg::MAX_BURST-1:0][POS_BITS-1:0] cand_start,
	output logic                                         room,
	output logic                                         head_vld,
	input  logic                                         pop,
	output ctok_pkg::tok_t                               head_tok,
	output logic [POS_BITS-1:0]                          head_start,
	output logic                                         head_last
);

	localparam int DEPTH = ctok_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ctok_pkg::tok_t      tok_mem   [DEPTH];
	logic [POS_BITS-1:0] start_mem [DEPTH];
	logic                last_mem  [DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic [ctok_pkg::MAX_BURST-1:0][PTR_W-1:0] slot_idx;
	logic [ctok_pkg::MAX_BURST-1:0]            is_last;
	logic [PTR_W-1:0]                          n_wr;
	logic                                      seen;
	logic                                      do_pop;

	// compact the valid tokens into consecutive entries, mark the final one
	always_comb begin
		n_wr = '0;
		for (int i = 0; i < ctok_pkg::MAX_BURST; i++) begin
			slot_idx[i] = wr_ptr_q + n_wr;
			if (cand_vld[i]) begin
				n_wr = n_wr + 1'b1;
			end
		end
		seen = 1'b0;
		for (int i = ctok_pkg::MAX_BURST - 1; i >= 0; i--) begin
			is_last[i] = cand_vld[i] && !seen;
			seen       = seen || cand_vld[i];
		end
	end

	assign room       = count_q <= CNT_W'(DEPTH - ctok_pkg::MAX_BURST);
	assign head_vld   = count_q != '0;
	assign do_pop     = pop && head_vld;
	assign head_tok   = tok_mem[rd_ptr_q];
	assign head_start = start_mem[rd_ptr_q];
	assign head_last  = last_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < ctok_pkg::MAX_BURST; i++) begin
				if (cand_vld[i]) begin
					tok_mem[slot_idx[i]]   <= cand_tok[i];
					start_mem[slot_idx[i]] <= cand_start[i];
					last_mem[slot_idx[i]]  <= is_last[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + n_wr;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (wr_en ? CNT_W'(n_wr) : CNT_W'(0))
				- (do_pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	`CTOK_ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`CTOK_ASSERT_NEXT(a_pop_drains, clk, arst_n, !wr_en && do_pop, count_q == $past(count_q) - 1'b1)
	`CTOK_ASSERT_SAME(a_no_overfill, clk, arst_n, wr_en, room)

endmodule

/* test/token_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_checker
// Watches both channels of the tokenizer, predicts the token stream from
// the accepted source bytes and compares every token that leaves the block.
// ----------------------------------------------------------------------------
module token_checker
	import ctok_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [CH_W-1:0]    ch,
	input  logic               end_of_text,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [KIND_W-1:0]  token_kind,
	input  logic [VALUE_W-1:0] int_value,
	input  logic [15:0]        start_pos,
	input  logic [LEN_W-1:0]   token_length,
	input  logic               overflow,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 tokens_owed
);

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [15:0]        pos;
		logic [LEN_W-1:0]   len;
		logic               ovf;
		logic               last;
	} token_t;

	token_t owed_q[$];
	token_t burst[MAX_BURST];
	int     burst_n = 0;

	// scanner copy
	logic [MODE_W-1:0] scan_mode = MODE_IDLE;
	logic [63:0]       num_acc   = '0;
	int                run_len   = 0;
	logic [KW_W-1:0]   kw_state  = KW_NONE;
	logic [15:0]       tok_pos   = '0;
	logic [15:0]       next_pos  = '0;
	logic              ovf_flag  = 1'b0;

	initial begin
		fail_count  = 0;
		tokens_owed = 0;
	end

	function automatic logic letter(input logic [CH_W-1:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic blank(input logic [CH_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [KW_W-1:0] kw_advance(input logic [KW_W-1:0] m,
			input logic [CH_W-1:0] c);
		case (m)
			KW_I:     return (c == CH_N) ? KW_IN : KW_NONE;
			KW_IN:    return (c == CH_T) ? KW_INT : KW_NONE;
			KW_R:     return (c == CH_E) ? KW_RE : KW_NONE;
			KW_RE:    return (c == CH_T) ? KW_RET : KW_NONE;
			KW_RET:   return (c == CH_U) ? KW_RETU : KW_NONE;
			KW_RETU:  return (c == CH_R) ? KW_RETUR : KW_NONE;
			KW_RETUR: return (c == CH_N) ? KW_RETURN : KW_NONE;
			default:  return KW_NONE;
		endcase
	endfunction

	task automatic push_token(input logic [KIND_W-1:0] kind, input logic [63:0] value,
			input logic [15:0] pos, input int len, input logic ovf);
		if (burst_n < MAX_BURST) begin
			burst[burst_n] = '{kind, value[VALUE_W-1:0], pos, len[LEN_W-1:0], ovf, 1'b0};
			burst_n++;
		end
	endtask

	task automatic clear_scan();
		scan_mode = MODE_IDLE;
		num_acc   = '0;
		run_len   = 0;
		kw_state  = KW_NONE;
		tok_pos   = '0;
		next_pos  = '0;
		ovf_flag  = 1'b0;
	endtask

	// one byte, or the end of text, at offset pos
	task automatic scan(input logic [CH_W-1:0] c, input logic at_end, input logic [15:0] pos);
		logic [CH_W-1:0]   pair;
		logic [KIND_W-1:0] two_k;
		logic [KIND_W-1:0] one_k;
		if (scan_mode >= MODE_OP_NOT && scan_mode <= MODE_OP_GT) begin
			case (scan_mode)
				MODE_OP_NOT: begin pair = CH_EQ;   two_k = KIND_NE;   one_k = KIND_NOT;    end
				MODE_OP_AND: begin pair = CH_AMP;  two_k = KIND_LAND; one_k = KIND_AMP;    end
				MODE_OP_OR:  begin pair = CH_PIPE; two_k = KIND_LOR;  one_k = KIND_PIPE;   end
				MODE_OP_EQ:  begin pair = CH_EQ;   two_k = KIND_EQEQ; one_k = KIND_ASSIGN; end
				MODE_OP_LT:  begin pair = CH_EQ;   two_k = KIND_LE;   one_k = KIND_LT;     end
				default:     begin pair = CH_EQ;   two_k = KIND_GE;   one_k = KIND_GT;     end
			endcase
			scan_mode = MODE_IDLE;
			if (!at_end && c == pair) begin
				push_token(two_k, 0, tok_pos, 2, 1'b0);
				return;
			end
			push_token(one_k, 0, tok_pos, 1, 1'b0);
		end else if (scan_mode == MODE_NUM) begin
			if (!at_end && c >= CH_ZERO && c <= CH_NINE) begin
				num_acc = num_acc * 10 + (c - CH_ZERO);
				if (num_acc > INT_MAX) begin
					num_acc  = INT_MAX;
					ovf_flag = 1'b1;
				end
				if (run_len < NUM_LEN_CAP) run_len++;
				return;
			end
			push_token(KIND_INT_LIT, num_acc, tok_pos, run_len, ovf_flag);
			scan_mode = MODE_IDLE;
		end else if (scan_mode == MODE_ID) begin
			if (!at_end && letter(c)) begin
				kw_state = kw_advance(kw_state, c);
				if (run_len < MAX_IDENT_LEN_DEF) run_len++;
				else ovf_flag = 1'b1;
				return;
			end
			if (kw_state == KW_INT && (at_end || blank(c)))
				push_token(KIND_KW_INT, 0, tok_pos, 3, 1'b0);
			else if (kw_state == KW_RETURN && (at_end || blank(c) || c == CH_SEMI))
				push_token(KIND_KW_RETURN, 0, tok_pos, 6, 1'b0);
			else
				push_token(KIND_IDENT, 0, tok_pos, run_len, ovf_flag);
			scan_mode = MODE_IDLE;
		end else begin
			scan_mode = MODE_IDLE;
		end

		if (at_end) begin
			push_token(KIND_EOF, 0, pos, 0, 1'b0);
			clear_scan();
			return;
		end
		if (c == CH_SPACE || c == CH_NL) return;
		tok_pos  = pos;
		num_acc  = '0;
		run_len  = 1;
		ovf_flag = 1'b0;
		kw_state = KW_NONE;
		case (c)
			CH_LBRACE: push_token(KIND_LBRACE, 0, pos, 1, 1'b0);
			CH_RBRACE: push_token(KIND_RBRACE, 0, pos, 1, 1'b0);
			CH_LPAREN: push_token(KIND_LPAREN, 0, pos, 1, 1'b0);
			CH_RPAREN: push_token(KIND_RPAREN, 0, pos, 1, 1'b0);
			CH_SEMI:   push_token(KIND_SEMI, 0, pos, 1, 1'b0);
			CH_MINUS:  push_token(KIND_MINUS, 0, pos, 1, 1'b0);
			CH_TILDE:  push_token(KIND_TILDE, 0, pos, 1, 1'b0);
			CH_PLUS:   push_token(KIND_PLUS, 0, pos, 1, 1'b0);
			CH_STAR:   push_token(KIND_STAR, 0, pos, 1, 1'b0);
			CH_SLASH:  push_token(KIND_SLASH, 0, pos, 1, 1'b0);
			CH_BANG:   scan_mode = MODE_OP_NOT;
			CH_AMP:    scan_mode = MODE_OP_AND;
			CH_PIPE:   scan_mode = MODE_OP_OR;
			CH_EQ:     scan_mode = MODE_OP_EQ;
			CH_LT:     scan_mode = MODE_OP_LT;
			CH_GT:     scan_mode = MODE_OP_GT;
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					scan_mode = MODE_NUM;
					num_acc   = 64'(c - CH_ZERO);
				end else begin
					scan_mode = MODE_ID;
					kw_state  = (c == CH_I) ? KW_I : (c == CH_R) ? KW_R : KW_NONE;
				end
			end
		endcase
	endtask

	// tokens caused by one input transaction, appended in order
	task automatic predict_tokens(input logic [CH_W-1:0] c, input logic last);
		logic [15:0] here;
		here    = next_pos;
		burst_n = 0;
		if (c == CH_NUL) begin
			scan(c, 1'b1, here);
		end else begin
			next_pos = here + 16'd1;
			scan(c, 1'b0, here);
			if (last) scan(CH_NUL, 1'b1, next_pos);
		end
		if (burst_n > 0) burst[burst_n-1].last = 1'b1;
		for (int i = 0; i < burst_n; i++) owed_q.push_back(burst[i]);
	endtask

	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) predict_tokens(ch, end_of_text);
			if (out_valid && !out_stall) begin
				got = '{token_kind, int_value, start_pos, token_length, overflow, last_of_run};
				if (owed_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected token: kind %0d value %0d pos %0d len %0d ovf %0d last %0d",
							got.kind, got.value, got.pos, got.len, got.ovf, got.last);
				end else begin
					want = owed_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("token mismatch: expected kind %0d value %0d pos %0d len %0d ovf %0d last %0d",
								want.kind, want.value, want.pos, want.len, want.ovf, want.last);
							$display("                got      kind %0d value %0d pos %0d len %0d ovf %0d last %0d",
								got.kind, got.value, got.pos, got.len, got.ovf, got.last);
						end
					end
				end
			end
			tokens_owed <= owed_q.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the tokenizer with directed texts, random C-like texts, noise bytes
// and one text with an over-long word and number, with random idling on both
// channels; the checker beside the block predicts and compares the tokens.
// ----------------------------------------------------------------------------
module tb_top;
	import ctok_pkg::*;

	localparam int IDLE_LIMIT   = 500;   // cycles without any transaction
	localparam int RANDOM_BYTES = 290;
	localparam int DRAIN_CYCLES = 20;

	typedef enum int {CLOSE_MARK, CLOSE_NUL, CLOSE_NUL_MARK, CLOSE_OPEN} close_e;

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            in_valid    = 1'b0;
	logic [CH_W-1:0] ch          = '0;
	logic            end_of_text = 1'b0;
	logic            out_stall   = 1'b1;

	logic               in_stall;
	logic               out_valid;
	logic [KIND_W-1:0]  token_kind;
	logic [VALUE_W-1:0] int_value;
	logic [15:0]        start_pos;
	logic [LEN_W-1:0]   token_length;
	logic               overflow;
	logic               last_of_run;

	int fail_count;
	int tokens_owed;
	int quiet_cycles = 0;
	int counted      = 0;
	bit calm         = 1'b0; // no idling on either side while set

	logic [CH_W-1:0] text_q[$];

	string near_words[6] = '{"in", "retur", "intx", "returns", "i", "r"};
	string single_ops    = "{}();-~+*/";
	string pair_ops      = "!&|=<>";

	always #4 clk = ~clk;

	c_subset_tokenizer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch           (ch),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.int_value    (int_value),
		.start_pos    (start_pos),
		.token_length (token_length),
		.overflow     (overflow),
		.last_of_run  (last_of_run)
	);

	token_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch           (ch),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.int_value    (int_value),
		.start_pos    (start_pos),
		.token_length (token_length),
		.overflow     (overflow),
		.last_of_run  (last_of_run),
		.fail_count   (fail_count),
		.tokens_owed  (tokens_owed)
	);

	// Watchdog: end the run when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Token sink: hold stall for a random number of cycles per token, then
	// take it. Sample at the falling edge, act at the rising one.
	initial begin
		int wait_n;
		repeat (7) @(posedge clk);
		forever begin
			wait_n = calm ? 0 : $urandom_range(0, 11);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	// Drive one byte transaction after a random gap and return at the edge that takes it.
	task automatic send_byte(input logic [CH_W-1:0] c, input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		ch          <= c;
		end_of_text <= last;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		counted++;
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	// Send the buffered text and close it the way asked; empty the buffer.
	task automatic send_text(input close_e how);
		int n;
		n = text_q.size();
		if (how == CLOSE_MARK && n == 0) begin
			send_byte(CH_NUL, 1'b0);
		end else begin
			for (int i = 0; i < n; i++)
				send_byte(text_q[i], how == CLOSE_MARK && i == n - 1);
			if (how == CLOSE_NUL) send_byte(CH_NUL, 1'b0);
			if (how == CLOSE_NUL_MARK) send_byte(CH_NUL, 1'b1);
		end
		text_q.delete();
	endtask

	// Build a C-like text: keywords, near keywords, words, numbers, operators,
	// stray bytes, with assorted separators or none at all.
	task automatic build_text();
		int pieces;
		int sel;
		int n;
		logic [CH_W-1:0] b;
		pieces = $urandom_range(1, 8);
		for (int p = 0; p < pieces; p++) begin
			sel = $urandom_range(0, 19);
			if (sel <= 1) begin
				add_str("int");
			end else if (sel <= 3) begin
				add_str("return");
			end else if (sel == 4) begin
				add_str(near_words[$urandom_range(0, 5)]);
			end else if (sel <= 7) begin
				n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					b = $urandom_range(0, 1) ? CH_W'(CH_LA + $urandom_range(0, 25))
						: CH_W'(CH_UA + $urandom_range(0, 25));
					text_q.push_back(b);
				end
			end else if (sel <= 10) begin
				if ($urandom_range(0, 29) == 0) n = $urandom_range(60, 66);
				else if ($urandom_range(0, 5) == 0) n = $urandom_range(9, 12);
				else n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					b = CH_W'(CH_ZERO + $urandom_range(0, 9));
					text_q.push_back(b);
				end
			end else if (sel <= 13) begin
				text_q.push_back(single_ops[$urandom_range(0, 9)]);
			end else if (sel <= 16) begin
				b = pair_ops[$urandom_range(0, 5)];
				text_q.push_back(b);
				// complete the two-byte form about half the time
				if ($urandom_range(0, 1))
					text_q.push_back((b == CH_AMP || b == CH_PIPE) ? b : CH_EQ);
			end else begin
				if ($urandom_range(0, 1)) begin
					b = CH_W'($urandom_range(128, 255));
				end else begin
					case ($urandom_range(0, 3))
						0: b = CH_TAB;
						1: b = 8'h0B;
						2: b = 8'h0C;
						default: b = CH_CR;
					endcase
				end
				text_q.push_back(b);
			end
			sel = $urandom_range(0, 9);
			if (sel <= 3) text_q.push_back(CH_SPACE);
			else if (sel == 4) text_q.push_back(CH_NL);
			else if (sel == 6) text_q.push_back(CH_SEMI);
			else if (sel == 7) text_q.push_back(CH_W'(CH_TAB + $urandom_range(0, 4)));
		end
	endtask

	initial begin
		int sel;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every punctuator and two-byte operator, an operator
		// cut off by the end, a zero byte that carries the end mark,
		// an empty text, and the highest byte as a lone identifier.
		add_str("{}();-~+*/!=&&||==<=>=");
		send_text(CLOSE_MARK);
		add_str("!");
		send_text(CLOSE_NUL_MARK);
		send_text(CLOSE_NUL);
		text_q.push_back(8'hFF);
		send_text(CLOSE_MARK);

		// Random: mostly well-formed texts, some raw noise bytes.
		counted = 0;
		while (counted < RANDOM_BYTES) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3))
					send_byte(CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				build_text();
				sel = $urandom_range(0, 9);
				if (sel <= 4) send_text(CLOSE_MARK);
				else if (sel <= 6) send_text(CLOSE_NUL);
				else if (sel == 7) send_text(CLOSE_NUL_MARK);
				else send_text(CLOSE_OPEN);
			end
		end

		// Long text: start fresh, then an over-long word and number.
		calm = 1'b0;
		send_text(CLOSE_NUL);
		add_str("abcd ");
		repeat (70) text_q.push_back(CH_W'(CH_LA + $urandom_range(0, 25)));
		text_q.push_back(CH_SPACE);
		repeat (65) text_q.push_back(CH_W'(CH_ZERO + $urandom_range(0, 9)));
		add_str(" int");
		send_text(CLOSE_MARK);
		in_valid <= 1'b0;

		// Drain: wait until every predicted token is out, then let the block settle.
		do @(negedge clk); while (tokens_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && tokens_owed == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
